/* rtl/core/pmc_pkg.sv */
`timescale 1ns / 1ps

package pmc_pkg;

    // Default cursor coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Field widths fixed by the byte format and the register map
    localparam int BYTE_BITS    = 8;
    localparam int SIZE_BITS    = 13;
    localparam int HOME_BITS    = 12;
    localparam int DX_BITS      = 9;
    localparam int DY_BITS      = 10;
    localparam int BTN_BITS     = 3;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;

    // Protocol bytes
    localparam logic [BYTE_BITS-1:0] ACK_BYTE  = 8'hFA;
    localparam logic [BYTE_BITS-1:0] HDR_MASK  = 8'hC8;
    localparam logic [BYTE_BITS-1:0] HDR_MATCH = 8'h08;
    localparam logic [BYTE_BITS-1:0] BTN_MASK  = 8'h07;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_ABSORBED   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_COMPLETE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNEXPECTED = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOME_X        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOME_Y        = 2'd3;

    // Register reset values
    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [HOME_BITS-1:0] HOME_X_RST        = 12'd312;
    localparam logic [HOME_BITS-1:0] HOME_Y_RST        = 12'd232;

endpackage

/* rtl/core/pmc_axis_clamp.sv */
`timescale 1ns / 1ps

// Move one cursor axis by a signed delta and clamp to 0 .. limit-1.
// The limit is the screen size, capped at 2^COORD_BITS, with zero taken as one.
module pmc_axis_clamp #(
    parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]             pos,
    input  logic signed [pmc_pkg::DY_BITS-1:0] delta,
    input  logic [pmc_pkg::SIZE_BITS-1:0]     size,
    output logic [COORD_BITS-1:0]             next_pos
);

    localparam int SW = (COORD_BITS + 2 > pmc_pkg::SIZE_BITS + 1) ?
                        COORD_BITS + 2 : pmc_pkg::SIZE_BITS + 1;

    logic [SW-1:0]        size_ext;
    logic [SW-1:0]        cap;
    logic [SW-1:0]        limit;
    logic signed [SW-1:0] sum;

    always_comb
    begin
        size_ext = SW'(size);
        cap      = SW'(1) << COORD_BITS;
        limit    = (size_ext > cap) ? cap : size_ext;
        if (limit == '0)
        begin
            limit = SW'(1);
        end
        sum = $signed({{(SW - COORD_BITS){1'b0}}, pos}) + SW'(delta);
        if (sum[SW-1])
        begin
            next_pos = '0;
        end
        else if ($unsigned(sum) >= limit)
        begin
            next_pos = COORD_BITS'(limit - SW'(1));
        end
        else
        begin
            next_pos = sum[COORD_BITS-1:0];
        end
    end

endmodule

/* rtl/core/ps2_mouse_packet_cursor.sv */
`timescale 1ns / 1ps

// PS/2 mouse three-byte packet decoder with a clamped cursor.
// Each accepted byte's result is on the master side in the cycle after it.
// Throughput: 1 byte per cycle while the output register is empty or being
// drained; the per-byte update is one combinational pass into that register.
// Reset (rst_n, async, active low): wait for acknowledge, registers at defaults
// (640 x 480, home 312/232), cursor at home, last packet fields cleared.
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [pmc_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
    input  logic [pmc_pkg::SIZE_BITS-1:0]       cfg_wdata,
    // Byte stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pmc_pkg::BYTE_BITS-1:0]       s_tdata,   // [7:0] data_byte
    // Result stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // from bit 0: status, buttons, delta_x, delta_y, cursor_x, cursor_y, zero fill
    output logic [((24 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_RAW = 24 + 2 * COORD_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // Frame phase codes
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_X    = 2'd2;
    localparam logic [1:0] PH_Y    = 2'd3;

    // Configuration registers
    logic [pmc_pkg::SIZE_BITS-1:0] screen_width_reg;
    logic [pmc_pkg::SIZE_BITS-1:0] screen_height_reg;
    logic [pmc_pkg::HOME_BITS-1:0] home_x_reg;
    logic [pmc_pkg::HOME_BITS-1:0] home_y_reg;

    // Decoder state
    logic [1:0]                          phase_reg,   phase_next;
    logic [pmc_pkg::BYTE_BITS-1:0]       header_reg,  header_next;
    logic [pmc_pkg::BYTE_BITS-1:0]       xbyte_reg,   xbyte_next;
    logic [pmc_pkg::BTN_BITS-1:0]        buttons_reg, buttons_next;
    logic signed [pmc_pkg::DX_BITS-1:0]  dx_reg,      dx_next;
    logic signed [pmc_pkg::DY_BITS-1:0]  dy_reg,      dy_next;
    logic [COORD_BITS-1:0]               pos_x_reg,   pos_x_next;
    logic [COORD_BITS-1:0]               pos_y_reg,   pos_y_next;

    // Output register
    logic                                m_valid_reg;
    logic [pmc_pkg::STATUS_BITS-1:0]     status_reg,  status_next;

    logic                                in_xact;
    logic signed [pmc_pkg::DX_BITS-1:0]  pkt_dx;
    logic signed [pmc_pkg::DY_BITS-1:0]  pkt_dy;
    logic signed [pmc_pkg::DX_BITS-1:0]  raw_dy;
    logic [COORD_BITS-1:0]               clamp_x;
    logic [COORD_BITS-1:0]               clamp_y;

    // Take a byte whenever the output register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign in_xact  = s_tvalid && s_tready;

    // Deltas of the packet that the current byte would complete
    assign pkt_dx = $signed({header_reg[4], xbyte_reg});
    assign raw_dy = $signed({header_reg[5], s_tdata});
    assign pkt_dy = -pmc_pkg::DY_BITS'(raw_dy);

    pmc_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .pos      (pos_x_reg),
        .delta    (pmc_pkg::DY_BITS'(pkt_dx)),
        .size     (screen_width_reg),
        .next_pos (clamp_x)
    );

    pmc_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .pos      (pos_y_reg),
        .delta    (pkt_dy),
        .size     (screen_height_reg),
        .next_pos (clamp_y)
    );

    // Per-byte decode
    always_comb
    begin
        phase_next   = phase_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        buttons_next = buttons_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        status_next  = pmc_pkg::ST_ABSORBED;
        case (phase_reg)
            PH_WAIT:
            begin
                if (s_tdata == pmc_pkg::ACK_BYTE)
                begin
                    // Acknowledge: start framing and home the cursor
                    phase_next = PH_HDR;
                    pos_x_next = COORD_BITS'(home_x_reg);
                    pos_y_next = COORD_BITS'(home_y_reg);
                end
                else
                begin
                    status_next = pmc_pkg::ST_UNEXPECTED;
                end
            end
            PH_HDR:
            begin
                // Drop bytes that do not look like a header
                if ((s_tdata & pmc_pkg::HDR_MASK) == pmc_pkg::HDR_MATCH)
                begin
                    header_next = s_tdata;
                    phase_next  = PH_X;
                end
            end
            PH_X:
            begin
                xbyte_next = s_tdata;
                phase_next = PH_Y;
            end
            PH_Y:
            begin
                buttons_next = pmc_pkg::BTN_BITS'(header_reg & pmc_pkg::BTN_MASK);
                dx_next      = pkt_dx;
                dy_next      = pkt_dy;
                pos_x_next   = clamp_x;
                pos_y_next   = clamp_y;
                phase_next   = PH_HDR;
                status_next  = pmc_pkg::ST_COMPLETE;
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= pmc_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= pmc_pkg::SCREEN_HEIGHT_RST;
            home_x_reg        <= pmc_pkg::HOME_X_RST;
            home_y_reg        <= pmc_pkg::HOME_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pmc_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                pmc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                pmc_pkg::REG_HOME_X:
                    home_x_reg <= cfg_wdata[pmc_pkg::HOME_BITS-1:0];
                pmc_pkg::REG_HOME_Y:
                    home_y_reg <= cfg_wdata[pmc_pkg::HOME_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance decoder state on each input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            header_reg  <= '0;
            xbyte_reg   <= '0;
            buttons_reg <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            pos_x_reg   <= COORD_BITS'(pmc_pkg::HOME_X_RST);
            pos_y_reg   <= COORD_BITS'(pmc_pkg::HOME_Y_RST);
        end
        else if (in_xact)
        begin
            phase_reg   <= phase_next;
            header_reg  <= header_next;
            xbyte_reg   <= xbyte_next;
            buttons_reg <= buttons_next;
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
        end
    end

    // Output valid: set by an input transaction, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_xact)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Status payload; the other fields read straight from the state registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({pos_y_reg, pos_x_reg, dy_reg, dx_reg, buttons_reg, status_reg});

    // Ready drops only while a result is held
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_valid_reg)
        else $error("input stalled with empty output register");

    // Acknowledge while waiting starts framing and homes the cursor
    a_ack_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && phase_reg == PH_WAIT && s_tdata == pmc_pkg::ACK_BYTE) |=>
        (phase_reg == PH_HDR && status_reg == pmc_pkg::ST_ABSORBED &&
         pos_x_reg == COORD_BITS'($past(home_x_reg)) &&
         pos_y_reg == COORD_BITS'($past(home_y_reg))))
        else $error("acknowledge not handled");

    // Any other byte while waiting is flagged and keeps waiting
    a_unexpected: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && phase_reg == PH_WAIT && s_tdata != pmc_pkg::ACK_BYTE) |=>
        (phase_reg == PH_WAIT && status_reg == pmc_pkg::ST_UNEXPECTED))
        else $error("unexpected byte not flagged");

    // The third byte closes a packet and returns to header phase
    a_packet_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && phase_reg == PH_Y) |=>
        (phase_reg == PH_HDR && status_reg == pmc_pkg::ST_COMPLETE && m_valid_reg))
        else $error("packet not completed");

    // Once framing began, the decoder never goes back to waiting
    a_no_rewait: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_WAIT) |=> (phase_reg != PH_WAIT))
        else $error("decoder fell back to waiting");

endmodule
